>>> hdl/acpf_pkg.sv
// Shared types and constants for the AT command packet filter.
`default_nettype none

package acpf_pkg;

    // One received byte with its end-of-packet mark
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } cmd_beat_t;

    // Verdict for one packet
    typedef struct packed {
        logic       forward;
        logic       switch_on;
        logic [6:0] host_number;
        logic [6:0] remote_number;
    } res_beat_t;

    // Parser verdict handed to the top level for the id checks
    typedef struct packed {
        logic       good;
        logic       is_on;
        logic [6:0] host;
        logic [6:0] remote;
    } parse_res_t;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_BODY = 4'b0001,
        PH_OPTS = 4'b0010,
        PH_DONE = 4'b0100,
        PH_REJ  = 4'b1000
    } phase_t;

    // Register map (word index taken from paddr[2])
    localparam logic REG_HOST_ID    = 1'b0;
    localparam logic REG_REMOTE_IDS = 1'b1;

    localparam logic [4:0] BODY_MAX    = 5'd10;
    localparam logic [4:0] ON_LEN      = 5'd5;
    localparam logic [4:0] OFF_LEN     = 5'd6;
    localparam logic [4:0] PACKET_MAX  = 5'd17;
    localparam logic [4:0] POS_SAT     = 5'd31;
    localparam logic [2:0] OPT_NEEDED  = 3'd5;
    localparam logic [2:0] COMMA_POS   = 3'd2;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] MATCH_ON   = 2'b01;
    localparam logic [1:0] MATCH_OFF  = 2'b10;
    localparam logic [1:0] MATCH_BOTH = 2'b11;

    // "at+on" by position
    function automatic logic [7:0] on_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h61;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h2B;
            3'd3:    c = 8'h6F;
            3'd4:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "at+off" by position
    function automatic logic [7:0] off_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h61;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h2B;
            3'd3:    c = 8'h6F;
            3'd4:    c = 8'h66;
            3'd5:    c = 8'h66;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/at_command_packet_filter.sv
// Top level of the AT command packet filter: config registers, id match, result register.
`default_nettype none

// Packet filter for "at+on=HH,RR" / "at+off=HH,RR" radio commands. Bytes come
// in on the cmd channel one beat each, the final byte flagged by last_byte.
// The block takes one byte every cycle unless stalled; per-byte parse state
// (position, candidate body, option count, the two parsed numbers) updates
// at each beat. On the last byte a single verdict beat is written into the
// result register and shows on res. A packet passes when it is no longer than
// 17 bytes, its body before the first '=' is exactly at+on or at+off, and the
// following five bytes read two digits, a comma, two digits. forward is set
// when the first number equals host_id and the second equals one of the first
// REMOTES 8-bit slots of remote_ids (slot 0 in bits 7:0). For malformed
// packets switch_on and both numbers read zero; they are reported for
// well-formed packets even when the ids do not match. Option bytes beyond the
// five are ignored. cmd_ready drops only while a verdict sits unclaimed in the
// result register, so with res_ready held high the rate is one byte per
// clock. Registers: host_id at byte address 0 (reset 255), remote_ids at
// byte address 4 (reset 0xFFFFFFFF). Write them only between packets.

module at_command_packet_filter
    import acpf_pkg::*;
#(
    parameter int REMOTES = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream
    input  wire logic        byte_valid,
    output logic             cmd_ready,
    input  wire cmd_beat_t   cmd_data,
    // verdicts
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_beat_t        res_data,
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  host_id_reg;
    logic [31:0] remote_ids_reg;
    logic        apb_wr;

    logic        cmd_take;
    parse_res_t  pres;

    logic [REMOTES-1:0] slot_hit;
    logic               host_hit;
    res_beat_t          res_next;

    logic      res_valid_reg;
    res_beat_t res_data_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_id_reg    <= 8'hFF;
            remote_ids_reg <= 32'hFFFF_FFFF;
        end
        else if (apb_wr)
        begin
            unique case (paddr[2])
                REG_HOST_ID:    host_id_reg    <= pwdata[7:0];
                REG_REMOTE_IDS: remote_ids_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HOST_ID:    prdata = {24'd0, host_id_reg};
            REG_REMOTE_IDS: prdata = remote_ids_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- parse ----------------
    // Hold off new bytes only while a verdict is stuck in the result register
    assign cmd_ready = !res_valid_reg || res_ready;
    assign cmd_take  = byte_valid && cmd_ready;

    acpf_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (cmd_take),
        .byte_value (cmd_data.byte_value),
        .last_byte  (cmd_data.last_byte),
        .res        (pres)
    );

    // ---------------- id match ----------------
    // host_id above 99 can never match a two-digit number
    assign host_hit = (host_id_reg == {1'b0, pres.host});

    for (genvar k = 0; k < REMOTES; k++)
    begin : g_slot
        assign slot_hit[k] = (remote_ids_reg[8*k +: 8] == {1'b0, pres.remote});
    end

    assign res_next.forward       = pres.good && host_hit && (|slot_hit);
    assign res_next.switch_on     = pres.is_on;
    assign res_next.host_number   = pres.host;
    assign res_next.remote_number = pres.remote;

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd_take && cmd_data.last_byte)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_data.last_byte)
            res_data_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

>>> hdl/acpf_parse.sv
// Byte-wise packet parser: body match, option digits, length tracking.
`default_nettype none

module acpf_parse
    import acpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] byte_value,
    input  wire logic       last_byte,
    output parse_res_t      res
);

    logic [4:0] pos_reg, pos_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] match_reg, match_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [6:0] host_reg, host_next;
    logic [6:0] rem_reg, rem_next;
    logic       ok_reg, ok_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [10:0] host_acc;
    logic [10:0] rem_acc;
    logic        on_hit;
    logic        off_hit;
    logic        good;

    assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    assign digit    = byte_value[3:0];
    assign host_acc = 11'(host_reg) * 11'd10 + 11'(digit);
    assign rem_acc  = 11'(rem_reg) * 11'd10 + 11'(digit);
    assign on_hit   = match_reg[0] && (pos_reg == ON_LEN) && (pos_reg <= BODY_MAX);
    assign off_hit  = match_reg[1] && (pos_reg == OFF_LEN) && (pos_reg <= BODY_MAX);

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        cnt_next   = cnt_reg;
        host_next  = host_reg;
        rem_next   = rem_reg;
        ok_next    = ok_reg;
        unique case (phase_reg)
            PH_BODY:
            begin
                if (byte_value == CH_EQ)
                begin
                    if (on_hit || off_hit)
                    begin
                        match_next = on_hit ? MATCH_ON : MATCH_OFF;
                        phase_next = PH_OPTS;
                    end
                    else
                    begin
                        phase_next = PH_REJ;
                    end
                end
                else
                begin
                    match_next[0] = match_reg[0] && (pos_reg < ON_LEN)
                                    && (byte_value == on_char(pos_reg[2:0]));
                    match_next[1] = match_reg[1] && (pos_reg < OFF_LEN)
                                    && (byte_value == off_char(pos_reg[2:0]));
                end
            end
            PH_OPTS:
            begin
                if (cnt_reg == COMMA_POS)
                begin
                    if (byte_value != CH_COMMA)
                        ok_next = 1'b0;
                end
                else if (!is_digit)
                begin
                    ok_next = 1'b0;
                end
                else if (ok_reg)
                begin
                    if (cnt_reg < COMMA_POS)
                        host_next = host_acc[6:0];
                    else
                        rem_next = rem_acc[6:0];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_next >= OPT_NEEDED)
                    phase_next = PH_DONE;
            end
            PH_DONE, PH_REJ:
            begin
            end
            default:
            begin
            end
        endcase
        pos_next = (pos_reg < POS_SAT) ? pos_reg + 5'd1 : pos_reg;
    end

    assign good = (pos_next <= PACKET_MAX) && (phase_next == PH_DONE) && ok_next;

    assign res.good   = good;
    assign res.is_on  = good && (match_next == MATCH_ON);
    assign res.host   = good ? host_next : 7'd0;
    assign res.remote = good ? rem_next : 7'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_BODY;
            match_reg <= MATCH_BOTH;
            cnt_reg   <= '0;
            host_reg  <= '0;
            rem_reg   <= '0;
            ok_reg    <= 1'b1;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                phase_reg <= PH_BODY;
                match_reg <= MATCH_BOTH;
                cnt_reg   <= '0;
                host_reg  <= '0;
                rem_reg   <= '0;
                ok_reg    <= 1'b1;
            end
            else
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                match_reg <= match_next;
                cnt_reg   <= cnt_next;
                host_reg  <= host_next;
                rem_reg   <= rem_next;
                ok_reg    <= ok_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/acpf_checker.sv
// Port-level checker for the AT command packet filter, bound to the top level.
`default_nettype none

module acpf_checker
    import acpf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        cmd_ready,
    input wire cmd_beat_t   cmd_data,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire res_beat_t   res_data
);

    // Stalled verdict holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("verdict changed while stalled");

    // A verdict only follows an accepted last byte
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(byte_valid && cmd_ready && cmd_data.last_byte))
        else $error("verdict without last byte");

    // No byte taken while a verdict is stuck
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("byte accepted over stalled verdict");

    // Parsed numbers are two decimal digits at most
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.host_number <= 7'd99) && (res_data.remote_number <= 7'd99))
        else $error("parsed number out of range");

endmodule

bind at_command_packet_filter acpf_checker u_acpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
);

`default_nettype wire
